FILE: rtl/box_blur_3x3_clipped_top_defines.svh
// ---------------------------------------------------------------------------
// Box blur assertion macros
// Shared assertion helpers. Each macro expects clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_CLIPPED_TOP_DEFINES_SVH
`define BOX_BLUR_3X3_CLIPPED_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define BBC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define BBC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BBC_ASSERT_NOW(lbl, ante, cons)
`define BBC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/bbc_pkg.sv
// ---------------------------------------------------------------------------
// Box blur package
// Shared types, widths and the rounding divider used by the back end.
// ---------------------------------------------------------------------------
package bbc_pkg;

  localparam int COL_W   = 12;
  localparam int ROW_W   = 13;
  localparam int X_W     = 13;
  localparam int Q_DEPTH = 4;
  localparam int QP_W    = 2;

  typedef logic [23:0] pix_t;

  // Odd factor of the divisor after the power of two is shifted out.
  typedef enum logic [1:0] {
    DIV_BY_1 = 2'd0,
    DIV_BY_3 = 2'd1,
    DIV_BY_9 = 2'd2
  } div_t;

  // One input pixel's work: the shifted window and its place in the frame.
  typedef struct packed {
    pix_t [8:0]       win;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             row_end;
    logic             last_row;
  } job_t;

  // One result between the summing stage and the divide stage.
  typedef struct packed {
    logic [X_W-1:0] x_b;
    logic [X_W-1:0] x_g;
    logic [X_W-1:0] x_r;
    logic [1:0]     shift;
    div_t           div;
    logic [11:0]    row;
    logic [10:0]    col;
    logic           last;
    logic           frame;
  } calc_t;

  // Quotient of x by 2^shift * {1,3,9}, via a reciprocal and one correction.
  function automatic logic [7:0] bbc_div(logic [X_W-1:0] x, logic [1:0] shift, div_t d);
    logic [X_W-1:0] y;
    logic [24:0]    prod;
    logic [X_W-1:0] q;
    logic [X_W+1:0] rem;
    y    = x >> shift;
    q    = y;
    prod = '0;
    rem  = '0;
    case (d)
      DIV_BY_1: q = y;
      DIV_BY_3: begin
        prod = 25'(y) * 25'd2730;
        q    = X_W'(prod[24:13]);
        rem  = 15'(y) - (15'(q) + (15'(q) << 1));
        if (rem >= 15'd3) q = q + 13'd1;
      end
      DIV_BY_9: begin
        prod = 25'(y) * 25'd910;
        q    = X_W'(prod[24:13]);
        rem  = 15'(y) - (15'(q) + (15'(q) << 3));
        if (rem >= 15'd9) q = q + 13'd1;
      end
      default: q = y;
    endcase
    return q[7:0];
  endfunction

endpackage

FILE: rtl/bbc_front.sv
// ---------------------------------------------------------------------------
// Box blur front end
// Accepts pixels, tracks the frame position, reads and updates the line
// store and shifts the 3x3 window, then hands one job per pixel onward.
// ---------------------------------------------------------------------------
module bbc_front #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_blue,
  input  logic [7:0]           in_green,
  input  logic [7:0]           in_red,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [12:0]          cfg_wdata,
  output bbc_pkg::job_t        job_o,
  output logic                 push_o,
  input  logic                 full_i
);
  import bbc_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  logic [11:0]      width_r;
  logic [12:0]      height_r;
  logic [ROW_W-1:0] row_r;
  logic [COL_W-1:0] col_r;
  logic [11:0]      w_eff;
  logic [12:0]      h_eff;
  logic             row_end, last_row, accept, done;
  logic [AW-1:0]    addr;

  logic             s1_valid_r;
  pix_t             s1_px_r;
  logic [ROW_W-1:0] s1_row_r;
  logic [COL_W-1:0] s1_col_r;
  logic [AW-1:0]    s1_addr_r;
  logic             s1_row_end_r, s1_last_row_r;

  logic [47:0]      line_mem [MAX_WIDTH];
  logic [47:0]      rd_mem_r, fwd_data_r;
  logic             fwd_sel_r;
  pix_t             up_v, mid_v;
  pix_t [8:0]       win_r, win_nxt;

  // Sizes as used: zero acts as one, large values clip to the maximum.
  always_comb begin
    if (width_r == 12'd0) w_eff = 12'd1;
    else if (int'(width_r) > MAX_WIDTH) w_eff = 12'(MAX_WIDTH);
    else w_eff = width_r;
    if (height_r == 13'd0) h_eff = 13'd1;
    else if (int'(height_r) > MAX_HEIGHT) h_eff = 13'(MAX_HEIGHT);
    else h_eff = height_r;
  end

  assign row_end  = ({1'b0, col_r} + 13'd1) >= {1'b0, w_eff};
  assign last_row = ({1'b0, row_r} + 14'd1) >= {1'b0, h_eff};
  assign addr     = AW'(col_r);

  // A word moves into stage one whenever stage one is empty or can drain.
  assign in_ready = !s1_valid_r || !full_i;
  assign accept   = in_valid && in_ready;
  assign done     = s1_valid_r && !full_i;

  // Configuration and frame position.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 12'd640;
      height_r <= 13'd480;
      row_r    <= '0;
      col_r    <= '0;
    end else if (cfg_we) begin
      if (cfg_index == 1'b0) width_r <= cfg_wdata[11:0];
      else height_r <= cfg_wdata;
      row_r <= '0;
      col_r <= '0;
    end else if (accept) begin
      if (row_end) begin
        col_r <= '0;
        row_r <= last_row ? '0 : row_r + 13'd1;
      end else begin
        col_r <= col_r + 12'd1;
      end
    end
  end

  // Stage one control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (done) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Stage one payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px_r       <= {in_red, in_green, in_blue};
      s1_row_r      <= row_r;
      s1_col_r      <= col_r;
      s1_addr_r     <= addr;
      s1_row_end_r  <= row_end;
      s1_last_row_r <= last_row;
    end
  end

  // Line store: each entry holds the upper and middle rows of one column.
  always_ff @(posedge clk) begin
    if (done) line_mem[s1_addr_r] <= {mid_v, s1_px_r};
    if (accept) rd_mem_r <= line_mem[addr];
  end

  // Forward an entry written in the same cycle as it is read (one-pixel rows).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_sel_r <= 1'b0;
    end else if (accept) begin
      fwd_sel_r <= done && (s1_addr_r == addr);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) fwd_data_r <= {mid_v, s1_px_r};
  end

  assign up_v  = fwd_sel_r ? fwd_data_r[47:24] : rd_mem_r[47:24];
  assign mid_v = fwd_sel_r ? fwd_data_r[23:0]  : rd_mem_r[23:0];

  // Window shifts left by one column and takes the new column on the right.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r*3]   = win_r[r*3+1];
      win_nxt[r*3+1] = win_r[r*3+2];
    end
    win_nxt[2] = up_v;
    win_nxt[5] = mid_v;
    win_nxt[8] = s1_px_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (done) begin
      win_r <= win_nxt;
    end
  end

  assign push_o         = done;
  assign job_o.win      = win_nxt;
  assign job_o.row      = s1_row_r;
  assign job_o.col      = s1_col_r;
  assign job_o.row_end  = s1_row_end_r;
  assign job_o.last_row = s1_last_row_r;

endmodule

FILE: rtl/bbc_queue.sv
// ---------------------------------------------------------------------------
// Box blur job queue
// A short register queue that lets the front and back ends stall apart.
// ---------------------------------------------------------------------------
`include "box_blur_3x3_clipped_top_defines.svh"

module bbc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_i,
  input  bbc_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          head_valid_o,
  output bbc_pkg::job_t head_o
);
  import bbc_pkg::*;

  job_t            q_r [Q_DEPTH];
  logic [QP_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QP_W:0]   count_r;

  assign full_o       = count_r == (QP_W+1)'(Q_DEPTH);
  assign head_valid_o = count_r != '0;
  assign head_o       = q_r[rd_ptr_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_i) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop_i) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push_i && !pop_i) count_r <= count_r + 1'b1;
      else if (pop_i && !push_i) count_r <= count_r - 1'b1;
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push_i) q_r[wr_ptr_r] <= data_i;
  end

  `BBC_ASSERT_NOW(a_no_overflow, push_i, !full_o)
  `BBC_ASSERT_NOW(a_no_underflow, pop_i, head_valid_o)
  `BBC_ASSERT_NEXT(a_count_steady, push_i && pop_i, $stable(count_r))

endmodule

FILE: rtl/bbc_back.sv
// ---------------------------------------------------------------------------
// Box blur back end
// Expands each job into its zero to four results, sums the clipped
// neighborhood, then divides with rounding into the output register.
// ---------------------------------------------------------------------------
module bbc_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid_i,
  input  bbc_pkg::job_t job_i,
  output logic          pop_o,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_blue,
  output logic [7:0]    out_green,
  output logic [7:0]    out_red,
  output logic [11:0]   out_row,
  output logic [10:0]   out_col,
  output logic          out_last_of_run,
  output logic          out_frame_done
);
  import bbc_pkg::*;

  logic        en;
  logic [3:0]  emit, done_r, pend, sel;
  logic [1:0]  k;
  logic        is_last;
  logic        i_ge1, i_ge2, j_ge1, j_ge2;
  logic [1:0]  cr, cc;
  logic        top, bottom, left, right;
  logic [2:0]  rm, cm;
  logic [11:0] sum_b, sum_g, sum_r;
  logic [3:0]  cnt;
  calc_t       calc, b_r;
  logic        b_valid_r, out_valid_r;
  logic [7:0]  blue_r, green_r, red_r;
  logic [11:0] row_r;
  logic [10:0] col_r;
  logic        last_r, frame_r;

  // The whole pipe moves when the output register is free or being taken.
  assign en = !out_valid_r || out_ready;

  // Which results this pixel completes, in raster order.
  assign i_ge1   = job_i.row != '0;
  assign i_ge2   = job_i.row > 13'd1;
  assign j_ge1   = job_i.col != '0;
  assign j_ge2   = job_i.col > 12'd1;
  assign emit[0] = i_ge1 && j_ge1;
  assign emit[1] = i_ge1 && job_i.row_end;
  assign emit[2] = job_i.last_row && j_ge1;
  assign emit[3] = job_i.last_row && job_i.row_end;
  assign pend    = emit & ~done_r;
  assign sel     = pend & (~pend + 4'd1);
  assign is_last = (pend & ~sel) == 4'd0;
  assign pop_o   = head_valid_i && ((pend == 4'd0) || (en && is_last));

  always_comb begin
    case (sel)
      4'b0001: k = 2'd0;
      4'b0010: k = 2'd1;
      4'b0100: k = 2'd2;
      4'b1000: k = 2'd3;
      default: k = 2'd0;
    endcase
  end

  // Center cell and which sides of it lie inside the image.
  always_comb begin
    cr     = k[1] ? 2'd2 : 2'd1;
    cc     = k[0] ? 2'd2 : 2'd1;
    top    = k[1] ? i_ge1 : i_ge2;
    bottom = !k[1];
    left   = k[0] ? j_ge1 : j_ge2;
    right  = !k[0];
    for (int r = 0; r < 3; r++) begin
      rm[r] = (2'(r) == cr) || (top && 2'(r) == cr - 2'd1) ||
              (bottom && 2'(r) == cr + 2'd1);
      cm[r] = (2'(r) == cc) || (left && 2'(r) == cc - 2'd1) ||
              (right && 2'(r) == cc + 2'd1);
    end
  end

  // Clipped neighborhood sums.
  always_comb begin
    sum_b = '0;
    sum_g = '0;
    sum_r = '0;
    for (int n = 0; n < 9; n++) begin
      if (rm[n/3] && cm[n%3]) begin
        sum_b = sum_b + 12'(job_i.win[n][7:0]);
        sum_g = sum_g + 12'(job_i.win[n][15:8]);
        sum_r = sum_r + 12'(job_i.win[n][23:16]);
      end
    end
  end

  // Count and the split of the divisor 2*count into a shift and an odd factor.
  always_comb begin
    cnt = 4'($countones(rm)) * 4'($countones(cm));
    case (cnt)
      4'd1:    begin calc.shift = 2'd1; calc.div = DIV_BY_1; end
      4'd2:    begin calc.shift = 2'd2; calc.div = DIV_BY_1; end
      4'd3:    begin calc.shift = 2'd1; calc.div = DIV_BY_3; end
      4'd4:    begin calc.shift = 2'd3; calc.div = DIV_BY_1; end
      4'd6:    begin calc.shift = 2'd2; calc.div = DIV_BY_3; end
      4'd9:    begin calc.shift = 2'd1; calc.div = DIV_BY_9; end
      default: begin calc.shift = 2'd1; calc.div = DIV_BY_1; end
    endcase
    calc.x_b   = {sum_b, 1'b0} + 13'(cnt);
    calc.x_g   = {sum_g, 1'b0} + 13'(cnt);
    calc.x_r   = {sum_r, 1'b0} + 13'(cnt);
    calc.row   = k[1] ? job_i.row[11:0] : job_i.row[11:0] - 12'd1;
    calc.col   = k[0] ? job_i.col[10:0] : job_i.col[10:0] - 11'd1;
    calc.last  = is_last;
    calc.frame = k == 2'd3;
  end

  // Results already given for the job at the head.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= '0;
    end else if (pop_o) begin
      done_r <= '0;
    end else if (en && head_valid_i) begin
      done_r <= done_r | sel;
    end
  end

  // Sum stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (en) begin
      b_valid_r <= head_valid_i && (pend != 4'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) b_r <= calc;
  end

  // Divide stage into the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      blue_r  <= bbc_div(b_r.x_b, b_r.shift, b_r.div);
      green_r <= bbc_div(b_r.x_g, b_r.shift, b_r.div);
      red_r   <= bbc_div(b_r.x_r, b_r.shift, b_r.div);
      row_r   <= b_r.row;
      col_r   <= b_r.col;
      last_r  <= b_r.last;
      frame_r <= b_r.frame;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_blue        = blue_r;
  assign out_green       = green_r;
  assign out_red         = red_r;
  assign out_row         = row_r;
  assign out_col         = col_r;
  assign out_last_of_run = last_r;
  assign out_frame_done  = frame_r;

endmodule

FILE: rtl/box_blur_3x3_clipped_top.sv
// ---------------------------------------------------------------------------
// Box blur 3x3, clipped at the edges
// Streaming RGB box blur with two line stores and a decoupled back end.
// ---------------------------------------------------------------------------
// Pixels enter in raster order on the in_ channel (valid/ready), one word
// per pixel. Each blurred pixel leaves on the out_ channel with its row and
// column once its lower-right neighbor has arrived; one input gives zero to
// four words, the last flagged by out_last_of_run, and the frame's final
// pixel by out_frame_done.
// Sizes are to be written on the cfg_ port only while the block is idle,
// which the block itself does not enforce; a write restarts the frame at
// row 0, column 0. Inside the frame one input word is taken per cycle. The
// back end gives one result word per cycle, and a row end needs two
// results, the last row two results per pixel and its end four; the
// four-entry job queue absorbs short bursts, and once it is full the input
// waits for room. Reset clears the position, the window and the queue and
// sets 640 x 480; the line store needs no clearing. When out_ready is low
// the output word holds, the back end stops, and the front end stalls once
// the queue fills.
// ---------------------------------------------------------------------------
module box_blur_3x3_clipped_top #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_red,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [12:0] cfg_wdata,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_green,
  output logic [7:0]  out_red,
  output logic [11:0] out_row,
  output logic [10:0] out_col,
  output logic        out_last_of_run,
  output logic        out_frame_done
);
  import bbc_pkg::*;

  job_t job_in, job_head;
  logic push, full, pop, head_valid;

  bbc_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_blue   (in_blue),
    .in_green  (in_green),
    .in_red    (in_red),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .job_o     (job_in),
    .push_o    (push),
    .full_i    (full)
  );

  bbc_queue u_queue (
    .clk          (clk),
    .rst_n        (rst_n),
    .push_i       (push),
    .data_i       (job_in),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (job_head)
  );

  bbc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid_i    (head_valid),
    .job_i           (job_head),
    .pop_o           (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_blue        (out_blue),
    .out_green       (out_green),
    .out_red         (out_red),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_last_of_run (out_last_of_run),
    .out_frame_done  (out_frame_done)
  );

endmodule

FILE: tb/box_blur_3x3_clipped_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Box blur 3x3 regression bench
// Streams RGB pixels through the block under several frame sizes. A local
// model of the window and the two line stores predicts every blurred word
// (channels, place and flags), and the bench checks the words in order.
// ---------------------------------------------------------------------------

// Expected blurred word.
typedef struct packed {
  logic [7:0]  blue;
  logic [7:0]  green;
  logic [7:0]  red;
  logic [11:0] row;
  logic [10:0] col;
  logic        last;
  logic        frame;
} blur_word_t;

class blur_scoreboard;
  localparam int LINE_DEPTH = 2048;
  localparam int MAX_ROWS   = 4096;

  logic [11:0] width_reg;
  logic [12:0] height_reg;
  logic [23:0] upper_line [LINE_DEPTH];
  logic [23:0] middle_line [LINE_DEPTH];
  logic [23:0] win [9];
  int unsigned row_pos;
  int unsigned col_pos;
  blur_word_t  pending [$];
  int unsigned mismatches;

  function new();
    width_reg  = 12'd640;
    height_reg = 13'd480;
    foreach (win[k]) win[k] = '0;
    row_pos    = 0;
    col_pos    = 0;
    mismatches = 0;
  endfunction

  // A size write restarts the frame.
  function void set_size(bit idx, logic [12:0] value);
    if (idx == 1'b0) width_reg = value[11:0];
    else height_reg = value;
    row_pos = 0;
    col_pos = 0;
  endfunction

  // Rounded mean over the window block rows r0..r1, columns c0..c1.
  function blur_word_t window_mean(int r0, int r1, int c0, int c1,
                                   int unsigned row, int unsigned col);
    blur_word_t  w;
    int unsigned sum [3];
    int unsigned cnt;
    sum = '{0, 0, 0};
    cnt = (r1 - r0 + 1) * (c1 - c0 + 1);
    for (int r = r0; r <= r1; r++)
      for (int c = c0; c <= c1; c++)
        for (int ch = 0; ch < 3; ch++)
          sum[ch] += (win[r * 3 + c] >> (8 * ch)) & 8'hFF;
    w.blue  = 8'((2 * sum[0] + cnt) / (2 * cnt));
    w.green = 8'((2 * sum[1] + cnt) / (2 * cnt));
    w.red   = 8'((2 * sum[2] + cnt) / (2 * cnt));
    w.row   = 12'(row);
    w.col   = 11'(col);
    w.last  = 1'b0;
    w.frame = 1'b0;
    return w;
  endfunction

  // Note an accepted pixel and queue the words it completes.
  function void note_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
    int unsigned w_eff, h_eff, i, j, n;
    bit row_end, last_row;
    blur_word_t w;
    w_eff = (width_reg == 0) ? 1 : (width_reg > LINE_DEPTH ? LINE_DEPTH : width_reg);
    h_eff = (height_reg == 0) ? 1 : (height_reg > MAX_ROWS ? MAX_ROWS : height_reg);
    i = row_pos;
    j = col_pos;
    row_end  = (j + 1 >= w_eff);
    last_row = (i + 1 >= h_eff);
    n = 0;
    for (int k = 0; k < 3; k++) begin
      win[k * 3]     = win[k * 3 + 1];
      win[k * 3 + 1] = win[k * 3 + 2];
    end
    win[2] = upper_line[j];
    win[5] = middle_line[j];
    win[8] = {r, g, b};
    upper_line[j]  = middle_line[j];
    middle_line[j] = {r, g, b};

    if (i >= 1 && j >= 1) begin
      pending.push_back(window_mean(i >= 2 ? 0 : 1, 2, j >= 2 ? 0 : 1, 2, i - 1, j - 1));
      n++;
    end
    if (i >= 1 && row_end) begin
      pending.push_back(window_mean(i >= 2 ? 0 : 1, 2, j >= 1 ? 1 : 2, 2, i - 1, j));
      n++;
    end
    if (last_row && j >= 1) begin
      pending.push_back(window_mean(i >= 1 ? 1 : 2, 2, j >= 2 ? 0 : 1, 2, i, j - 1));
      n++;
    end
    if (last_row && row_end) begin
      w = window_mean(i >= 1 ? 1 : 2, 2, j >= 1 ? 1 : 2, 2, i, j);
      w.frame = 1'b1;
      pending.push_back(w);
      n++;
    end
    if (n > 0) pending[pending.size() - 1].last = 1'b1;

    if (row_end) begin
      col_pos = 0;
      row_pos = last_row ? 0 : i + 1;
    end else begin
      col_pos = j + 1;
    end
  endfunction

  // Compare one accepted word with the oldest expectation.
  function void check_word(blur_word_t got);
    blur_word_t exp_w;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected word row %0d col %0d", got.row, got.col);
      return;
    end
    exp_w = pending.pop_front();
    if (got !== exp_w) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp b%0d g%0d r%0d row%0d col%0d l%0d f%0d, %s",
                 exp_w.blue, exp_w.green, exp_w.red, exp_w.row, exp_w.col,
                 exp_w.last, exp_w.frame,
                 $sformatf("got b%0d g%0d r%0d row%0d col%0d l%0d f%0d",
                           got.blue, got.green, got.red, got.row, got.col,
                           got.last, got.frame));
    end
  endfunction
endclass

module box_blur_3x3_clipped_top_tb;
  localparam int IDX_WIDTH  = 0;
  localparam int IDX_HEIGHT = 1;
  localparam int STALL_LIMIT = 4000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_blue;
  logic [7:0]  in_green;
  logic [7:0]  in_red;
  logic        cfg_we;
  logic        cfg_index;
  logic [12:0] cfg_wdata;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_blue;
  logic [7:0]  out_green;
  logic [7:0]  out_red;
  logic [11:0] out_row;
  logic [10:0] out_col;
  logic        out_last_of_run;
  logic        out_frame_done;

  blur_scoreboard board;
  int unsigned    idle_cycles;
  bit             stall_free;

  box_blur_3x3_clipped_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_blue(in_blue), .in_green(in_green), .in_red(in_red),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_blue(out_blue), .out_green(out_green), .out_red(out_red),
    .out_row(out_row), .out_col(out_col),
    .out_last_of_run(out_last_of_run), .out_frame_done(out_frame_done)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Mostly no gap or a short one, sometimes a long one; none when stall_free.
  function automatic int unsigned gap_len();
    if (stall_free) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(30, 8);
    return $urandom_range(3) == 0 ? $urandom_range(2) : 0;
  endfunction

  // Result side: random stalls, check every accepted word.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_word('{out_blue, out_green, out_red, out_row, out_col,
                         out_last_of_run, out_frame_done});
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= (gap_len() == 0);
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("box_blur_3x3_clipped_top regression: fail");
      $finish;
    end
  end

  task automatic write_size(int idx, logic [12:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx[0];
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_size(idx[0], value);
    @(posedge clk);
  endtask

  // Send one pixel word, holding it until accepted.
  task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
    int unsigned gap;
    gap = gap_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_blue  <= b;
    in_green <= g;
    in_red   <= r;
    do @(posedge clk); while (!in_ready);
    board.note_pixel(b, g, r);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // One phase: set sizes, then stream the given count of random or extreme pixels.
  task automatic run_phase(logic [12:0] w, logic [12:0] h, int unsigned pixels,
                           bit extremes);
    logic [7:0] v;
    write_size(IDX_WIDTH, w);
    write_size(IDX_HEIGHT, h);
    for (int unsigned k = 0; k < pixels; k++) begin
      if (extremes) begin
        v = (k % 2 == 0) ? 8'hFF : 8'h00;
        send_pixel(v, ~v, (k % 3 == 0) ? 8'hFF : 8'h00);
      end else begin
        send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
      end
    end
    drain();
  endtask

  initial begin
    board       = new();
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_blue     = '0;
    in_green    = '0;
    in_red      = '0;
    cfg_we      = 1'b0;
    cfg_index   = 1'b0;
    cfg_wdata   = '0;
    out_ready   = 1'b0;
    idle_cycles = 0;
    stall_free  = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes of channels, single pixel, thin images, zero sizes.
    run_phase(13'd3, 13'd3, 9, 1'b1);
    run_phase(13'd1, 13'd1, 2, 1'b0);
    run_phase(13'd0, 13'd0, 1, 1'b0);
    run_phase(13'd1, 13'd4, 4, 1'b0);
    run_phase(13'd5, 13'd1, 5, 1'b0);

    // Random frames; partial frame ends are fine since a write restarts.
    stall_free = 1'b1;
    run_phase(13'd4, 13'd3, 24, 1'b0);
    stall_free = 1'b0;
    run_phase(13'd7, 13'd5, 70, 1'b0);
    run_phase(13'd2, 13'd6, 24, 1'b0);
    run_phase(13'd9, 13'd2, 27, 1'b0);
    run_phase(13'd3, 13'd8, 48, 1'b0);
    // Oversized sizes clip to the maximum; only the first pixels are sent.
    run_phase(13'd4095, 13'd8191, 25, 1'b0);
    run_phase(13'd2048, 13'd4096, 20, 1'b0);
    run_phase(13'd640, 13'd480, 10, 1'b0);

    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("box_blur_3x3_clipped_top regression: pass");
    else
      $display("box_blur_3x3_clipped_top regression: fail");
    $finish;
  end
endmodule
